### design/usr_pkg.sv
// Shared types and constants for the urn signaling reinforcement unit.
`default_nettype none

package usr_pkg;

	localparam int W_W    = 32;
	localparam int CNT_W  = 4;
	localparam int SUM_W  = 36;
	localparam int KEEP_W = 17;
	localparam int DRAW_W = 16;
	localparam int IDX_W  = 3;

	localparam logic [KEEP_W-1:0] KEEP_ONE = 17'h10000;

	localparam logic [1:0] REG_STATES  = 2'd0;
	localparam logic [1:0] REG_SIGNALS = 2'd1;
	localparam logic [1:0] REG_KEEP    = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0]  states_in_use;
		logic [CNT_W-1:0]  signals_in_use;
		logic [KEEP_W-1:0] keep_factor;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] true_state;
		logic [IDX_W-1:0] chosen_signal;
		logic [IDX_W-1:0] chosen_act;
		logic             success;
	} res_t;

endpackage

`default_nettype wire

### design/usr_wmem.sv
// Weight memory: one write port, one read port, registered read data.
`default_nettype none

module usr_wmem import usr_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic           clk,
	input  wire logic           rd_en,
	input  wire logic [AW-1:0]  rd_addr,
	output logic      [W_W-1:0] rd_data,
	input  wire logic           wr_en,
	input  wire logic [AW-1:0]  wr_addr,
	input  wire logic [W_W-1:0] wr_data
);

	logic [W_W-1:0] mem_q [DEPTH];
	logic [W_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/usr_ctrl.sv
// Round sequencer: row sums, roulette scans, forgetting sweep and reinforcement.
`default_nettype none

module usr_ctrl import usr_pkg::*; #(
	parameter int MAX_STATES       = 8,
	parameter int MAX_SIGNALS      = 8,
	parameter int WEIGHT_FRAC_BITS = 16,
	parameter int DEPTH            = MAX_STATES * MAX_SIGNALS,
	parameter int AW               = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [DRAW_W-1:0] state_draw,
	input  wire logic [DRAW_W-1:0] sender_draw,
	input  wire logic [DRAW_W-1:0] receiver_draw,
	input  wire cfg_t              cfg,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res,
	output logic                   s_rd_en,
	output logic      [AW-1:0]     s_rd_addr,
	input  wire logic [W_W-1:0]    s_rd_data,
	output logic                   s_wr_en,
	output logic      [AW-1:0]     s_wr_addr,
	output logic      [W_W-1:0]    s_wr_data,
	output logic                   r_rd_en,
	output logic      [AW-1:0]     r_rd_addr,
	input  wire logic [W_W-1:0]    r_rd_data,
	output logic                   r_wr_en,
	output logic      [AW-1:0]     r_wr_addr,
	output logic      [W_W-1:0]    r_wr_data
);

	localparam int UW = $clog2(DEPTH + 1);
	localparam logic [W_W-1:0] ONE = W_W'(64'd1 << WEIGHT_FRAC_BITS);
	localparam logic [CNT_W-1:0] ST_CAP = CNT_W'((MAX_STATES > 15) ? 15 : MAX_STATES);
	localparam logic [CNT_W-1:0] SG_CAP = CNT_W'((MAX_SIGNALS > 15) ? 15 : MAX_SIGNALS);
	localparam int PW = W_W + KEEP_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SUM, ST_CALC, ST_SCAN, ST_UPD, ST_DRAIN, ST_DONE
	} state_t;

	state_t state_q;

	logic [AW-1:0]     clr_q;
	logic [DRAW_W-1:0] sdraw_q, rdraw_q;
	logic [CNT_W-1:0]  t_q, s_q, a_q, cnt_q, idx_s1, pick_q;
	logic              ok_q, rcv_q, v_s1, found_q;
	logic [SUM_W-1:0]  sum_q, acc_q, r_q;
	logic [UW-1:0]     upd_q;

	logic              u_s1, u_s2, sh_s1, rh_s1, sh_s2, rh_s2;
	logic [AW-1:0]     sa_s1, ra_s1, sa_s2, ra_s2;
	logic [PW-1:0]     sp_s2, rp_s2;

	logic [CNT_W-1:0]  n_st, n_sg, n_cur;
	logic [W_W-1:0]    rd_cur;
	logic [SUM_W-1:0]  acc_nx;
	logic [DRAW_W-1:0] draw_cur;
	logic [SUM_W+DRAW_W-1:0] r_prod;
	logic [DRAW_W+CNT_W-1:0] t_prod;
	logic [AW-1:0]     row_addr, s_tgt, r_tgt, s_addr, r_addr;
	logic              row_issue, upd_issue, forget, row_end;
	logic [UW-1:0]     upd_n;
	logic [KEEP_W-1:0] keep_eff;
	logic [W_W:0]      s_sum, r_sum;

	assign n_st = (cfg.states_in_use == '0) ? CNT_W'(1) :
		(cfg.states_in_use > ST_CAP) ? ST_CAP : cfg.states_in_use;
	assign n_sg = (cfg.signals_in_use == '0) ? CNT_W'(1) :
		(cfg.signals_in_use > SG_CAP) ? SG_CAP : cfg.signals_in_use;
	assign n_cur    = rcv_q ? n_st : n_sg;
	assign rd_cur   = rcv_q ? r_rd_data : s_rd_data;
	assign acc_nx   = acc_q + SUM_W'(rd_cur);
	assign draw_cur = rcv_q ? rdraw_q : sdraw_q;
	assign r_prod   = (SUM_W+DRAW_W)'(draw_cur) * (SUM_W+DRAW_W)'(sum_q);
	assign t_prod   = (DRAW_W+CNT_W)'(state_draw) * (DRAW_W+CNT_W)'(n_st);

	assign forget   = cfg.keep_factor < KEEP_ONE;
	assign keep_eff = forget ? cfg.keep_factor : KEEP_ONE;
	assign upd_n    = forget ? UW'(DEPTH) : (ok_q ? UW'(1) : UW'(0));

	assign row_addr = rcv_q ? AW'(32'(s_q) * MAX_STATES + 32'(cnt_q))
		: AW'(32'(t_q) * MAX_SIGNALS + 32'(cnt_q));
	assign s_tgt    = AW'(32'(t_q) * MAX_SIGNALS + 32'(s_q));
	assign r_tgt    = AW'(32'(s_q) * MAX_STATES + 32'(a_q));

	assign row_issue = (state_q == ST_SUM || state_q == ST_SCAN) && (cnt_q != n_cur);
	assign row_end   = (cnt_q == n_cur) && !v_s1;
	assign upd_issue = (state_q == ST_UPD) && (upd_q != upd_n);

	assign s_addr = forget ? upd_q[AW-1:0] : s_tgt;
	assign r_addr = forget ? upd_q[AW-1:0] : r_tgt;

	assign s_rd_en   = (row_issue && !rcv_q) || upd_issue;
	assign r_rd_en   = (row_issue && rcv_q) || upd_issue;
	assign s_rd_addr = (state_q == ST_UPD) ? s_addr : row_addr;
	assign r_rd_addr = (state_q == ST_UPD) ? r_addr : row_addr;

	// stage 2: rescale and reinforce, saturating
	assign s_sum = {1'b0, sp_s2[W_W+15:16]} + (sh_s2 ? {1'b0, ONE} : '0);
	assign r_sum = {1'b0, rp_s2[W_W+15:16]} + (rh_s2 ? {1'b0, ONE} : '0);

	assign s_wr_en   = (state_q == ST_CLEAR) || u_s2;
	assign r_wr_en   = (state_q == ST_CLEAR) || u_s2;
	assign s_wr_addr = (state_q == ST_CLEAR) ? clr_q : sa_s2;
	assign r_wr_addr = (state_q == ST_CLEAR) ? clr_q : ra_s2;
	assign s_wr_data = (state_q == ST_CLEAR) ? ONE : (s_sum[W_W] ? '1 : s_sum[W_W-1:0]);
	assign r_wr_data = (state_q == ST_CLEAR) ? ONE : (r_sum[W_W] ? '1 : r_sum[W_W-1:0]);

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.true_state    = t_q[IDX_W-1:0];
	assign res.chosen_signal = s_q[IDX_W-1:0];
	assign res.chosen_act    = a_q[IDX_W-1:0];
	assign res.success       = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			rcv_q   <= 1'b0;
			found_q <= 1'b0;
			ok_q    <= 1'b0;
			upd_q   <= '0;
		end else begin
			v_s1   <= row_issue;
			idx_s1 <= cnt_q;
			if (row_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (go) begin
						sdraw_q <= sender_draw;
						rdraw_q <= receiver_draw;
						t_q     <= t_prod[DRAW_W+CNT_W-1:DRAW_W];
						rcv_q   <= 1'b0;
						cnt_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (v_s1) begin
						sum_q <= sum_q + SUM_W'(rd_cur);
					end
					if (row_end) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					r_q     <= r_prod[SUM_W+DRAW_W-1:DRAW_W];
					cnt_q   <= '0;
					acc_q   <= '0;
					found_q <= 1'b0;
					pick_q  <= n_cur - CNT_W'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (v_s1) begin
						acc_q <= acc_nx;
						if (!found_q && acc_nx >= r_q) begin
							found_q <= 1'b1;
							pick_q  <= idx_s1;
						end
					end
					if (row_end) begin
						if (!rcv_q) begin
							s_q     <= pick_q;
							rcv_q   <= 1'b1;
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SUM;
						end else begin
							a_q     <= pick_q;
							ok_q    <= (pick_q == t_q);
							upd_q   <= '0;
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (upd_issue) begin
						upd_q <= upd_q + UW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!u_s1 && !u_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_s1 <= 1'b0;
			u_s2 <= 1'b0;
		end else begin
			u_s1 <= upd_issue;
			u_s2 <= u_s1;
		end
	end

	always_ff @(posedge clk) begin
		sa_s1 <= s_addr;
		ra_s1 <= r_addr;
		sh_s1 <= ok_q && (s_addr == s_tgt);
		rh_s1 <= ok_q && (r_addr == r_tgt);
		sa_s2 <= sa_s1;
		ra_s2 <= ra_s1;
		sh_s2 <= sh_s1;
		rh_s2 <= rh_s1;
		sp_s2 <= PW'(s_rd_data) * PW'(keep_eff);
		rp_s2 <= PW'(r_rd_data) * PW'(keep_eff);
	end

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM || state_q == ST_SCAN) |-> (!s_wr_en && !r_wr_en))
		else $error("weight write during row scan");

	a_success_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.success == (a_q == t_q)))
		else $error("success flag disagrees with chosen act");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((t_q < n_st) && (a_q < n_st) && (s_q < n_sg)))
		else $error("chosen index outside the rows in use");

	a_drained_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!u_s1 && !u_s2))
		else $error("update pipeline busy while idle");

endmodule

`default_nettype wire

### design/urn_signaling_reinforcement_unit.sv
// Top level of the urn signaling reinforcement unit.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | state_draw, sender_draw, receiver_draw
//  out      | out_valid / out_ready  | true_state, chosen_signal, chosen_act, success
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// One request at a time; each weight memory does one read per cycle for the row
// scans and the forgetting sweep. After reset a clearing pass loads 1.0 into
// all MAX_STATES*MAX_SIGNALS entries; in_ready stays low meanwhile. A result
// waiting on out_ready holds the next request at its end.
`default_nettype none

module urn_signaling_reinforcement_unit import usr_pkg::*; #(
	parameter int MAX_STATES       = 8,
	parameter int MAX_SIGNALS      = 8,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DRAW_W-1:0] state_draw,
	input  wire logic [DRAW_W-1:0] sender_draw,
	input  wire logic [DRAW_W-1:0] receiver_draw,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [IDX_W-1:0]  true_state,
	output logic      [IDX_W-1:0]  chosen_signal,
	output logic      [IDX_W-1:0]  chosen_act,
	output logic                   success,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [KEEP_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_STATES * MAX_SIGNALS;
	localparam int AW    = $clog2(DEPTH);

	cfg_t           cfg_q;
	res_t           res, out_q;
	logic           out_valid_q, idle, res_valid, res_ready;
	logic           s_rd_en, s_wr_en, r_rd_en, r_wr_en;
	logic [AW-1:0]  s_rd_addr, s_wr_addr, r_rd_addr, r_wr_addr;
	logic [W_W-1:0] s_rd_data, s_wr_data, r_rd_data, r_wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.states_in_use  <= CNT_W'(2);
			cfg_q.signals_in_use <= CNT_W'(2);
			cfg_q.keep_factor    <= KEEP_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STATES:  cfg_q.states_in_use  <= cfg_data[CNT_W-1:0];
				REG_SIGNALS: cfg_q.signals_in_use <= cfg_data[CNT_W-1:0];
				REG_KEEP:    cfg_q.keep_factor    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready  = idle;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign true_state    = out_q.true_state;
	assign chosen_signal = out_q.chosen_signal;
	assign chosen_act    = out_q.chosen_act;
	assign success       = out_q.success;

	usr_ctrl #(
		.MAX_STATES      (MAX_STATES),
		.MAX_SIGNALS     (MAX_SIGNALS),
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
		.DEPTH           (DEPTH),
		.AW              (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (in_valid && idle),
		.state_draw   (state_draw),
		.sender_draw  (sender_draw),
		.receiver_draw(receiver_draw),
		.cfg          (cfg_q),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.s_rd_en      (s_rd_en),
		.s_rd_addr    (s_rd_addr),
		.s_rd_data    (s_rd_data),
		.s_wr_en      (s_wr_en),
		.s_wr_addr    (s_wr_addr),
		.s_wr_data    (s_wr_data),
		.r_rd_en      (r_rd_en),
		.r_rd_addr    (r_rd_addr),
		.r_rd_data    (r_rd_data),
		.r_wr_en      (r_wr_en),
		.r_wr_addr    (r_wr_addr),
		.r_wr_data    (r_wr_data)
	);

	usr_wmem #(.DEPTH(DEPTH), .AW(AW)) u_sender_mem (
		.clk    (clk),
		.rd_en  (s_rd_en),
		.rd_addr(s_rd_addr),
		.rd_data(s_rd_data),
		.wr_en  (s_wr_en),
		.wr_addr(s_wr_addr),
		.wr_data(s_wr_data)
	);

	usr_wmem #(.DEPTH(DEPTH), .AW(AW)) u_receiver_mem (
		.clk    (clk),
		.rd_en  (r_rd_en),
		.rd_addr(r_rd_addr),
		.rd_data(r_rd_data),
		.wr_en  (r_wr_en),
		.wr_addr(r_wr_addr),
		.wr_data(r_wr_data)
	);

endmodule

`default_nettype wire
